/* design/sprd_pkg.sv */
// Shared types, constants and arithmetic helpers for the sparse row accumulator.
package sprd_pkg;

  localparam int K_DEPTH_DEF = 256;
  localparam int N_COLS_DEF  = 64;

  localparam int POS_W  = 8;
  localparam int COL_W  = 6;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 32;
  localparam int SUM_W  = 40;
  localparam int CNT_W  = 7;

  localparam logic [CNT_W-1:0] COLS_RESET = 7'd64;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_WEIGHT = 2'd1,
    KIND_FINISH = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic             sat;
    logic [SUM_W-1:0] sum;
  } acc_word_t;

  typedef struct packed {
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
    acc_word_t        wr_data;
    logic             clr;
  } acc_ctl_t;

  // Adds a product to an accumulator and clamps to the 40-bit range.
  // Returns the overflow flag above the clamped sum.
  function automatic logic [SUM_W:0] sat_add(input logic [SUM_W-1:0] acc,
                                             input logic [PROD_W-1:0] prod);
    logic [SUM_W:0] wide;
    logic [SUM_W:0] res;
    wide = {acc[SUM_W-1], acc} + {{(SUM_W+1-PROD_W){prod[PROD_W-1]}}, prod};
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      if (wide[SUM_W]) begin
        res = {1'b1, 1'b1, {(SUM_W-1){1'b0}}};
      end else begin
        res = {1'b1, 1'b0, {(SUM_W-1){1'b1}}};
      end
    end else begin
      res = {1'b0, wide[SUM_W-1:0]};
    end
    return res;
  endfunction

endpackage

/* design/sparse_row_times_dense_accumulator.sv */
// Top level of the sparse activation row times dense weight accumulator.
//
// Input words (in_*) carry a kind in in_tuser: load an activation element,
// add a weight element, or finish the row. Loads and weights are taken one
// per cycle. A weight word reads the activation store, multiplies, registers
// the product, then adds it into its column accumulator and writes it back; a
// column written by the word just ahead is forwarded, so back-to-back words to
// the same column are summed correctly.
// A finish word stops input while the multiply-add pipeline empties, then
// reads the accumulators out one per cycle on out_*: one word per column in
// use, tlast on the final one, tuser as the saturation flag. Each read passes
// through the pending and output registers before it is offered; in_tready
// stays low until every column in use has reached the output register.
// The accumulator memory's single read port, shared with the pipeline, is
// why the drain waits for the pipeline to empty.
// When the receiver stalls, the drain pauses with one word held in the
// output register and one read pending; nothing is lost.
// Reset clears the accumulators, sets columns_in_use to 64, and leaves the
// activation store undefined. Positions at or above K_DEPTH are ignored.
module sparse_row_times_dense_accumulator #(
  parameter int K_DEPTH = sprd_pkg::K_DEPTH_DEF,
  parameter int N_COLS  = sprd_pkg::N_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // position[7:0], column[13:8], value[29:14]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_column[5:0], sum[45:6]
  output logic        out_tuser,  // saturated[0]
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);

  localparam int ACT_DEPTH = (K_DEPTH < 256) ? K_DEPTH : 256;
  localparam int AW        = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;

  // Input decode
  sprd_pkg::kind_t                 in_kind;
  logic [sprd_pkg::POS_W-1:0]      in_pos;
  logic [sprd_pkg::COL_W-1:0]      in_col;
  logic [sprd_pkg::VAL_W-1:0]      in_val;
  logic                            in_acc;
  logic                            pos_ok;
  logic                            col_ok;
  logic                            load_go;
  logic                            weight_go;
  logic                            finish_go;

  // Configuration and drain control
  logic [sprd_pkg::CNT_W-1:0]      cfg_r;
  logic [sprd_pkg::CNT_W-1:0]      count_r;
  logic [sprd_pkg::CNT_W-1:0]      iss_cnt_r;
  sprd_pkg::state_t                state_r;
  sprd_pkg::state_t                state_nxt;
  logic                            acc_clr;
  logic                            issue;

  // Multiply-add pipeline
  logic                            s1_v_r;
  logic [sprd_pkg::COL_W-1:0]      s1_col_r;
  logic [sprd_pkg::VAL_W-1:0]      s1_val_r;
  logic [sprd_pkg::VAL_W-1:0]      act_rd;
  logic                            s2_v_r;
  logic [sprd_pkg::COL_W-1:0]      s2_col_r;
  logic [sprd_pkg::PROD_W-1:0]     s2_prod_r;
  logic                            fwd_v_r;
  sprd_pkg::acc_word_t             fwd_d_r;
  sprd_pkg::acc_word_t             acc_base;
  sprd_pkg::acc_word_t             acc_new;
  logic [sprd_pkg::SUM_W:0]        add_res;
  logic signed [sprd_pkg::PROD_W-1:0] prod;

  // Accumulator bank
  sprd_pkg::acc_ctl_t              bank_ctl;
  sprd_pkg::acc_word_t             bank_rd;

  // Drain and output stages
  logic                            p_v_r;
  logic [sprd_pkg::COL_W-1:0]      p_col_r;
  logic                            p_last_r;
  logic                            p_move;
  logic                            out_v_r;
  logic [sprd_pkg::COL_W-1:0]      out_col_r;
  sprd_pkg::acc_word_t             out_word_r;
  logic                            out_last_r;
  logic [sprd_pkg::CNT_W-1:0]      count_lim;

  assign in_kind = sprd_pkg::kind_t'(in_tuser);
  assign in_pos  = in_tdata[7:0];
  assign in_col  = in_tdata[13:8];
  assign in_val  = in_tdata[29:14];

  assign in_tready = (state_r == sprd_pkg::ST_RUN);
  assign in_acc    = in_tvalid && in_tready;
  assign pos_ok    = ({5'd0, in_pos} < 13'(K_DEPTH));
  assign col_ok    = ({1'b0, in_col} < 7'(N_COLS));
  assign load_go   = in_acc && (in_kind == sprd_pkg::KIND_LOAD) && pos_ok;
  assign weight_go = in_acc && (in_kind == sprd_pkg::KIND_WEIGHT) && pos_ok && col_ok;
  assign finish_go = in_acc && (in_kind == sprd_pkg::KIND_FINISH);

  assign count_lim = (cfg_r > 7'(N_COLS)) ? 7'(N_COLS) : cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= sprd_pkg::COLS_RESET;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  sprd_act_mem #(
    .DEPTH (ACT_DEPTH),
    .AW    (AW)
  ) u_act_mem (
    .clk       (clk),
    .wr_en     (load_go),
    .wr_addr   (in_pos[AW-1:0]),
    .wr_data   (in_val),
    .rd_en     (weight_go),
    .rd_addr   (in_pos[AW-1:0]),
    .rd_data_r (act_rd)
  );

  // Stage 1: activation is back from the store; multiply and read the column.
  assign prod = $signed(act_rd) * $signed(s1_val_r);

  // Stage 2: add with saturation and write the column back.
  assign acc_base    = fwd_v_r ? fwd_d_r : bank_rd;
  assign add_res     = sprd_pkg::sat_add(acc_base.sum, s2_prod_r);
  assign acc_new.sum = add_res[sprd_pkg::SUM_W-1:0];
  assign acc_new.sat = acc_base.sat | add_res[sprd_pkg::SUM_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      s1_v_r  <= weight_go;
      s2_v_r  <= s1_v_r;
      fwd_v_r <= s1_v_r && s2_v_r && (s2_col_r == s1_col_r);
    end
  end

  always_ff @(posedge clk) begin
    s1_col_r  <= in_col;
    s1_val_r  <= in_val;
    s2_col_r  <= s1_col_r;
    s2_prod_r <= prod;
    fwd_d_r   <= acc_new;
  end

  // Drain issues a read only when the pending slot will be free next cycle.
  assign p_move = p_v_r && (!out_v_r || out_tready);
  assign issue  = (state_r == sprd_pkg::ST_DRAIN) && (iss_cnt_r != count_r) &&
                  (!p_v_r || p_move);

  always_comb begin
    bank_ctl.rd_en   = s1_v_r || issue;
    bank_ctl.rd_addr = s1_v_r ? s1_col_r : iss_cnt_r[sprd_pkg::COL_W-1:0];
    bank_ctl.wr_en   = s2_v_r;
    bank_ctl.wr_addr = s2_col_r;
    bank_ctl.wr_data = acc_new;
    bank_ctl.clr     = acc_clr;
  end

  sprd_acc_bank #(
    .N_COLS (N_COLS)
  ) u_acc_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (bank_ctl),
    .rd_word (bank_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sprd_pkg::ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    acc_clr   = 1'b0;
    unique case (state_r)
      sprd_pkg::ST_RUN: begin
        if (finish_go) begin
          state_nxt = sprd_pkg::ST_FLUSH;
        end
      end
      sprd_pkg::ST_FLUSH: begin
        if (!s1_v_r && !s2_v_r) begin
          state_nxt = sprd_pkg::ST_DRAIN;
        end
      end
      sprd_pkg::ST_DRAIN: begin
        if ((iss_cnt_r == count_r) && !p_v_r) begin
          acc_clr   = 1'b1;
          state_nxt = sprd_pkg::ST_RUN;
        end
      end
      default: begin
        state_nxt = sprd_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      iss_cnt_r <= '0;
      p_v_r     <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (finish_go) begin
        count_r   <= count_lim;
        iss_cnt_r <= '0;
      end else if (issue) begin
        iss_cnt_r <= iss_cnt_r + 7'd1;
      end
      if (issue) begin
        p_v_r <= 1'b1;
      end else if (p_move) begin
        p_v_r <= 1'b0;
      end
      if (p_move) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_col_r  <= iss_cnt_r[sprd_pkg::COL_W-1:0];
      p_last_r <= ((iss_cnt_r + 7'd1) == count_r);
    end
    if (p_move) begin
      out_col_r  <= p_col_r;
      out_word_r <= bank_rd;
      out_last_r <= p_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_word_r.sum, out_col_r};
  assign out_tuser  = out_word_r.sat;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_drain_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sprd_pkg::ST_DRAIN) |-> (!s1_v_r && !s2_v_r))
    else $error("accumulator pipeline busy during drain");

  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (iss_cnt_r < count_r))
    else $error("drain read beyond columns in use");

  a_pending_held: assert property (@(posedge clk) disable iff (!rst_n)
    (p_v_r && out_v_r && !out_tready) |=> (p_v_r && $stable(p_col_r)))
    else $error("pending drain read lost under stall");

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc_clr |-> (!p_v_r && !s2_v_r))
    else $error("accumulators cleared with work in flight");
`endif

endmodule

/* design/sprd_act_mem.sv */
// Activation store: single write port, single registered read port.
module sprd_act_mem #(
  parameter int DEPTH = sprd_pkg::K_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [sprd_pkg::VAL_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [sprd_pkg::VAL_W-1:0]  rd_data_r
);

  logic [sprd_pkg::VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

/* design/sprd_acc_bank.sv */
// Column accumulator memory with per-entry valid bits; an invalid entry reads as zero.
module sprd_acc_bank #(
  parameter int N_COLS = sprd_pkg::N_COLS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sprd_pkg::acc_ctl_t  ctl,
  output sprd_pkg::acc_word_t rd_word
);

  localparam int CW = (N_COLS > 1) ? $clog2(N_COLS) : 1;

  sprd_pkg::acc_word_t mem [N_COLS];
  sprd_pkg::acc_word_t rd_data_r;
  logic [N_COLS-1:0]   valid_r;
  logic                rd_valid_r;
  logic [CW-1:0]       wa;
  logic [CW-1:0]       ra;

  assign wa = ctl.wr_addr[CW-1:0];
  assign ra = ctl.rd_addr[CW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wa] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[ra];
    end
  end

  // Clearing the valid bits empties every accumulator at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctl.clr) begin
        valid_r <= '0;
      end else if (ctl.wr_en) begin
        valid_r[wa] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_valid_r <= valid_r[ra];
      end
    end
  end

  assign rd_word = rd_valid_r ? rd_data_r : '0;

endmodule
